### src/mevd_pkg.sv
// ----------------------------------------------------------------------------
// mevd_pkg
// Types and codes shared by the message envelope deframer modules.
// ----------------------------------------------------------------------------
package mevd_pkg;

  localparam int unsigned QUEUE_AW_DEFAULT = 2;
  localparam logic [7:0] EXPECTED_VERSION_RESET = 8'd1;

  typedef enum logic [3:0] {
    PH_VERSION = 4'd0,
    PH_SLEN    = 4'd1,
    PH_SENDER  = 4'd2,
    PH_PLEN    = 4'd3,
    PH_PROTO   = 4'd4,
    PH_TTL     = 4'd5,
    PH_FLAG    = 4'd6,
    PH_EPOCH   = 4'd7,
    PH_BLEN    = 4'd8,
    PH_BODY    = 4'd9,
    PH_DONE    = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    KIND_SENDER = 3'd0,
    KIND_PROTO  = 3'd1,
    KIND_TTL    = 3'd2,
    KIND_FLAG   = 3'd3,
    KIND_EPOCH  = 3'd4,
    KIND_BLEN   = 3'd5,
    KIND_BODY   = 3'd6,
    KIND_END    = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_VERSION = 2'd1,
    ST_TRUNCATED   = 2'd2
  } status_t;

  localparam logic [3:0] TRUNC_NONE = 4'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_payload;
    logic       empty_payload;
  } item_t;

  typedef struct packed {
    logic [2:0]  field_kind;
    logic [63:0] value;
    logic [1:0]  status;
    logic [3:0]  truncated_at;
    logic        protocol_defaulted;
    logic        last_of_run;
  } result_t;

  // everything one input item causes: an optional field word and an optional end word
  typedef struct packed {
    logic        has_data;
    logic [2:0]  kind;
    logic [63:0] value;
    logic        has_end;
    logic [1:0]  status;
    logic [3:0]  trunc;
    logic        defaulted;
  } entry_t;

endpackage

### src/mevd_parse.sv
// ----------------------------------------------------------------------------
// mevd_parse
// Front end: takes one byte a cycle while take is high, tracks the envelope
// fields and builds one queue entry per item that causes any word.
// ----------------------------------------------------------------------------
module mevd_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  mevd_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  output logic              entry_we,
  output mevd_pkg::entry_t  entry
);

  logic [7:0]       expected_version;
  mevd_pkg::phase_t phase, phase_next;
  logic [31:0]      remaining, remaining_next;
  logic [63:0]      assembly, assembly_next;
  logic [2:0]       byte_index, byte_index_next;
  logic             proto_nonempty, proto_nonempty_next;
  logic             rejected, rejected_next;
  logic [63:0]      gathered;
  logic [7:0]       b;

  assign b = item.data_byte;

  // drop the new byte into the lane picked by the byte index
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      gathered[8*k +: 8] = (byte_index == 3'(k)) ? (assembly[8*k +: 8] | b)
                                                 : assembly[8*k +: 8];
    end
  end

  always_comb begin
    phase_next          = phase;
    remaining_next      = remaining;
    assembly_next       = assembly;
    byte_index_next     = byte_index;
    proto_nonempty_next = proto_nonempty;
    rejected_next       = rejected;
    entry               = '0;

    if (!item.empty_payload && !rejected) begin
      unique case (phase)
        mevd_pkg::PH_VERSION: begin
          if (b != expected_version) begin
            rejected_next = 1'b1;
            phase_next    = mevd_pkg::PH_DONE;
          end else begin
            phase_next = mevd_pkg::PH_SLEN;
          end
        end
        mevd_pkg::PH_SLEN: begin
          remaining_next = {24'd0, b};
          phase_next     = (b != 8'd0) ? mevd_pkg::PH_SENDER : mevd_pkg::PH_PLEN;
        end
        mevd_pkg::PH_SENDER: begin
          entry.has_data = 1'b1;
          entry.kind     = mevd_pkg::KIND_SENDER;
          entry.value    = {56'd0, b};
          remaining_next = remaining - 32'd1;
          if (remaining == 32'd1) begin
            phase_next = mevd_pkg::PH_PLEN;
          end
        end
        mevd_pkg::PH_PLEN: begin
          remaining_next      = {24'd0, b};
          proto_nonempty_next = (b != 8'd0);
          assembly_next       = '0;
          byte_index_next     = '0;
          phase_next          = (b != 8'd0) ? mevd_pkg::PH_PROTO : mevd_pkg::PH_TTL;
        end
        mevd_pkg::PH_PROTO: begin
          entry.has_data = 1'b1;
          entry.kind     = mevd_pkg::KIND_PROTO;
          entry.value    = {56'd0, b};
          remaining_next = remaining - 32'd1;
          if (remaining == 32'd1) begin
            assembly_next   = '0;
            byte_index_next = '0;
            phase_next      = mevd_pkg::PH_TTL;
          end
        end
        mevd_pkg::PH_TTL: begin
          if (byte_index >= 3'd3) begin
            entry.has_data  = 1'b1;
            entry.kind      = mevd_pkg::KIND_TTL;
            entry.value     = gathered;
            assembly_next   = '0;
            byte_index_next = '0;
            phase_next      = mevd_pkg::PH_FLAG;
          end else begin
            assembly_next   = gathered;
            byte_index_next = byte_index + 3'd1;
          end
        end
        mevd_pkg::PH_FLAG: begin
          entry.has_data  = 1'b1;
          entry.kind      = mevd_pkg::KIND_FLAG;
          entry.value     = {56'd0, b};
          assembly_next   = '0;
          byte_index_next = '0;
          phase_next      = mevd_pkg::PH_EPOCH;
        end
        mevd_pkg::PH_EPOCH: begin
          if (byte_index == 3'd7) begin
            entry.has_data  = 1'b1;
            entry.kind      = mevd_pkg::KIND_EPOCH;
            entry.value     = gathered;
            assembly_next   = '0;
            byte_index_next = '0;
            phase_next      = mevd_pkg::PH_BLEN;
          end else begin
            assembly_next   = gathered;
            byte_index_next = byte_index + 3'd1;
          end
        end
        mevd_pkg::PH_BLEN: begin
          if (byte_index >= 3'd3) begin
            entry.has_data  = 1'b1;
            entry.kind      = mevd_pkg::KIND_BLEN;
            entry.value     = gathered;
            remaining_next  = gathered[31:0];
            assembly_next   = '0;
            byte_index_next = '0;
            phase_next      = (gathered[31:0] != 32'd0) ? mevd_pkg::PH_BODY
                                                        : mevd_pkg::PH_DONE;
          end else begin
            assembly_next   = gathered;
            byte_index_next = byte_index + 3'd1;
          end
        end
        mevd_pkg::PH_BODY: begin
          entry.has_data = 1'b1;
          entry.kind     = mevd_pkg::KIND_BODY;
          entry.value    = {56'd0, b};
          remaining_next = remaining - 32'd1;
          if (remaining == 32'd1) begin
            phase_next = mevd_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    if (item.end_of_payload) begin
      entry.has_end = 1'b1;
      if (rejected_next) begin
        entry.status = mevd_pkg::ST_BAD_VERSION;
      end else if (phase_next == mevd_pkg::PH_VERSION) begin
        // no version byte seen: counts as version zero
        if (expected_version != 8'd0) begin
          entry.status = mevd_pkg::ST_BAD_VERSION;
        end else begin
          entry.status    = mevd_pkg::ST_TRUNCATED;
          entry.trunc     = mevd_pkg::PH_SLEN;
          entry.defaulted = 1'b1;
        end
      end else if (phase_next >= mevd_pkg::PH_DONE) begin
        entry.status    = mevd_pkg::ST_OK;
        entry.defaulted = !proto_nonempty_next;
      end else begin
        entry.status    = mevd_pkg::ST_TRUNCATED;
        entry.trunc     = phase_next;
        entry.defaulted = !(proto_nonempty_next && (phase_next > mevd_pkg::PH_PROTO));
      end
      phase_next          = mevd_pkg::PH_VERSION;
      remaining_next      = '0;
      assembly_next       = '0;
      byte_index_next     = '0;
      proto_nonempty_next = 1'b0;
      rejected_next       = 1'b0;
    end
  end

  assign entry_we = take && (entry.has_data || entry.has_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version <= mevd_pkg::EXPECTED_VERSION_RESET;
      phase            <= mevd_pkg::PH_VERSION;
      remaining        <= '0;
      assembly         <= '0;
      byte_index       <= '0;
      proto_nonempty   <= 1'b0;
      rejected         <= 1'b0;
    end else begin
      if (cfg_we) begin
        expected_version <= cfg_data;
      end
      if (take) begin
        phase          <= phase_next;
        remaining      <= remaining_next;
        assembly       <= assembly_next;
        byte_index     <= byte_index_next;
        proto_nonempty <= proto_nonempty_next;
        rejected       <= rejected_next;
      end
    end
  end

endmodule

### src/mevd_queue.sv
// ----------------------------------------------------------------------------
// mevd_queue
// Short entry queue between the parser and the word emitter.
// ----------------------------------------------------------------------------
module mevd_queue #(
  parameter int unsigned AW = mevd_pkg::QUEUE_AW_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  mevd_pkg::entry_t  wr_data,
  output logic              full,
  input  logic              rd_en,
  output mevd_pkg::entry_t  rd_data,
  output logic              avail
);

  localparam int unsigned DEPTH = 1 << AW;

  mevd_pkg::entry_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  assign full    = (count == (AW+1)'(DEPTH));
  assign avail   = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (AW+1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(wr_en && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(rd_en && !avail))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
      count <= (AW+1)'(DEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
      (wr_ptr - rd_ptr) == count[AW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

### src/mevd_emit.sv
// ----------------------------------------------------------------------------
// mevd_emit
// Back end: holds one entry and hands out its field word, then its end word.
// ----------------------------------------------------------------------------
module mevd_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_avail,
  input  mevd_pkg::entry_t  q_data,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output mevd_pkg::result_t result
);

  mevd_pkg::entry_t cur;
  logic             data_pend, end_pend;
  logic             take_word, last_word, reload;

  assign empty     = !(data_pend || end_pend);
  assign take_word = pop && !empty;
  assign last_word = data_pend ? !end_pend : 1'b1;
  // refill when nothing is held or the final word of this entry leaves
  assign reload    = empty || (take_word && last_word);
  assign q_rd      = reload && q_avail;

  always_comb begin
    result = '0;
    if (data_pend) begin
      result.field_kind  = cur.kind;
      result.value       = cur.value;
      result.last_of_run = !end_pend;
    end else begin
      result.field_kind         = mevd_pkg::KIND_END;
      result.status             = cur.status;
      result.truncated_at       = cur.trunc;
      result.protocol_defaulted = cur.defaulted;
      result.last_of_run        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_pend <= 1'b0;
      end_pend  <= 1'b0;
    end else if (reload) begin
      data_pend <= q_avail && q_data.has_data;
      end_pend  <= q_avail && q_data.has_end;
    end else if (take_word) begin
      data_pend <= 1'b0;
    end
  end

endmodule

### src/message_envelope_deframer_core.sv
// ----------------------------------------------------------------------------
// message_envelope_deframer_core
// Parses a byte stream into envelope fields and an end-of-payload status.
// ----------------------------------------------------------------------------
//  channel  | signals                        | word
//  ---------+--------------------------------+------------------------------
//  input    | push, full, item               | one payload byte + flags
//  result   | pop, empty, result             | field or end word
//  config   | cfg_valid, cfg_ready, cfg_data | expected version byte
//
//  one input word is taken every cycle while the entry queue has room
//  a result word can leave every cycle; an item that ends a
//  payload after a field byte gives two words, its field word then its end word
//  a pushed entry is registered in the queue, then in the output stage
//  synchronous reset clears parser state, queue and output stage; expected
//  version returns to 1; no clearing pass
// ----------------------------------------------------------------------------
module message_envelope_deframer_core #(
  parameter int unsigned QUEUE_AW = mevd_pkg::QUEUE_AW_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  mevd_pkg::item_t   item,
  input  logic              pop,
  output logic              empty,
  output mevd_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  logic             take;
  logic             entry_we;
  mevd_pkg::entry_t entry;
  logic             q_rd, q_avail;
  mevd_pkg::entry_t q_data;

  assign cfg_ready = 1'b1;
  assign take      = push && !full;

  mevd_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .entry_we (entry_we),
    .entry    (entry)
  );

  mevd_queue #(
    .AW (QUEUE_AW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (entry_we),
    .wr_data (entry),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_data),
    .avail   (q_avail)
  );

  mevd_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .q_avail (q_avail),
    .q_data  (q_data),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
